/* rtl/ile_pkg.sv */
package ile_pkg;

    typedef enum logic [3:0] {
        FN_GET     = 4'd0,
        FN_SET     = 4'd1,
        FN_APPEND  = 4'd2,
        FN_INSERT  = 4'd3,
        FN_POP     = 4'd4,
        FN_FIND    = 4'd5,
        FN_COUNT   = 4'd6,
        FN_REPLACE = 4'd7,
        FN_CLEAR   = 4'd8
    } ile_func_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_INSERT,
        OP_POP,
        OP_REPLACE
    } ile_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } ile_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_DONE
    } ile_state_t;

endpackage

/* rtl/ile_if.sv */
interface ile_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic signed [9:0] position;
    logic [31:0] item_value;
    logic [31:0] new_value;

    modport source (output valid, func, position, item_value, new_value, input ready);
    modport sink (input valid, func, position, item_value, new_value, output ready);
endinterface

interface ile_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [7:0]  found_index;
    logic [8:0]  match_count;
    logic [8:0]  list_len;
    logic [1:0]  status;

    modport source (output valid, read_value, found_index, match_count, list_len, status,
                    input ready);
    modport sink (input valid, read_value, found_index, match_count, list_len, status,
                  output ready);
endinterface

/* rtl/ile_cell.sv */
module ile_cell
    import ile_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int LW         = 9,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  ile_op_t               op,
    input  logic [LW-1:0]         pos,
    input  logic [LW-1:0]         len,
    input  logic [DATA_WIDTH-1:0] val,
    input  logic [DATA_WIDTH-1:0] nval,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] word,
    output logic [DATA_WIDTH-1:0] sel_word,
    output logic                  match
);

    localparam logic [LW-1:0] IDX = LW'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  live;

    assign live     = IDX < len;
    assign match    = live && (entry_reg == val);
    assign word     = entry_reg;
    assign sel_word = (IDX == pos) ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            OP_SET:
            begin
                if (IDX == pos)
                    entry_next = val;
            end
            OP_INSERT:
            begin
                if (IDX == pos)
                    entry_next = val;
                else if (IDX > pos)
                    entry_next = left_word;
            end
            OP_POP:
            begin
                if (IDX >= pos)
                    entry_next = right_word;
            end
            OP_REPLACE:
            begin
                if (match)
                    entry_next = nval;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/indexed_list_engine_unit.sv */
// channel | dir | fields
// req     | in  | func, position, item_value, new_value
// rsp     | out | read_value, found_index, match_count, list_len, status
//
// get, set, append, insert, pop, clear and unused codes: the item passes through S_APPLY,
// then the result is valid in S_DONE
// find, count and replace add an S_SCAN walk, one bit a cycle, over the
// registered match vector of the cell row
// one item at a time: req.ready is high only while idle, from the cycle after the
// result handshake; a held result stalls req
// reset empties the list; entry contents are not cleared
module indexed_list_engine_unit
    import ile_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    ile_req_if.sink   req,
    ile_rsp_if.source rsp
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = ((LW > 10) ? LW : 10) + 2;

    ile_state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] sc_reg, sc_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] fidx_reg, fidx_next;
    logic          found_reg, found_next;

    logic [3:0]            func_reg, func_next;
    ile_op_t               op_reg, op_next;
    logic [LW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] nval_reg, nval_next;
    logic [1:0]            st_reg, st_next;
    logic                  rd_en_reg, rd_en_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [CAPACITY-1:0]   match_reg, match_next;

    ile_op_t               cell_op;
    logic [DATA_WIDTH-1:0] words [CAPACITY];
    logic [DATA_WIDTH-1:0] sel_words [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic [DATA_WIDTH-1:0] rd_bus;

    logic signed [PW-1:0] pos_s;
    logic signed [PW-1:0] len_s;
    logic signed [PW-1:0] p;
    logic                 idx_ok;
    logic                 ins_ok;
    logic                 full;

    assign cell_op = (state_reg == S_APPLY) ? op_reg : OP_NONE;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] lw_word;
            logic [DATA_WIDTH-1:0] rw_word;
            if (gi == 0)
            begin : g_first
                assign lw_word = '0;
            end
            else
            begin : g_mid_l
                assign lw_word = words[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign rw_word = '0;
            end
            else
            begin : g_mid_r
                assign rw_word = words[gi+1];
            end
            ile_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .LW         (LW),
                .INDEX      (gi)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op),
                .pos        (pos_reg),
                .len        (len_reg),
                .val        (val_reg),
                .nval       (nval_reg),
                .left_word  (lw_word),
                .right_word (rw_word),
                .word       (words[gi]),
                .sel_word   (sel_words[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_bus = rd_bus | sel_words[i];
    end

    // resolve a negative position against the current length
    assign pos_s  = PW'(req.position);
    assign len_s  = PW'(len_reg);
    assign p      = pos_s + (req.position[9] ? len_s : PW'(0));
    assign idx_ok = !p[PW-1] && (p < len_s);
    assign ins_ok = !p[PW-1] && (p <= len_s);
    assign full   = len_reg >= LW'(CAPACITY);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        sc_next    = sc_reg;
        cnt_next   = cnt_reg;
        fidx_next  = fidx_reg;
        found_next = found_reg;
        func_next  = func_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        nval_next  = nval_reg;
        st_next    = st_reg;
        rd_en_next = rd_en_reg;
        rd_next    = rd_reg;
        match_next = match_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    pos_next   = LW'(p);
                    val_next   = DATA_WIDTH'(req.item_value);
                    nval_next  = DATA_WIDTH'(req.new_value);
                    op_next    = OP_NONE;
                    st_next    = ST_OK;
                    rd_en_next = 1'b0;
                    unique case (req.func)
                        FN_GET:
                        begin
                            if (idx_ok)
                                rd_en_next = 1'b1;
                            else
                                st_next = ST_NOTFOUND;
                        end
                        FN_SET:
                        begin
                            if (idx_ok)
                                op_next = OP_SET;
                            else
                                st_next = ST_NOTFOUND;
                        end
                        FN_APPEND:
                        begin
                            pos_next = len_reg;
                            if (full)
                                st_next = ST_FULL;
                            else
                                op_next = OP_INSERT;
                        end
                        FN_INSERT:
                        begin
                            if (!ins_ok)
                                st_next = ST_NOTFOUND;
                            else if (full)
                                st_next = ST_FULL;
                            else
                                op_next = OP_INSERT;
                        end
                        FN_POP:
                        begin
                            if (idx_ok)
                            begin
                                op_next    = OP_POP;
                                rd_en_next = 1'b1;
                            end
                            else
                                st_next = ST_NOTFOUND;
                        end
                        FN_REPLACE:
                        begin
                            op_next = OP_REPLACE;
                        end
                        FN_FIND, FN_COUNT, FN_CLEAR:
                        begin
                            op_next = OP_NONE;
                        end
                        default:
                        begin
                            st_next = ST_NOTFOUND;
                        end
                    endcase
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                rd_next    = rd_en_reg ? rd_bus : '0;
                match_next = match_vec;
                sc_next    = '0;
                cnt_next   = '0;
                fidx_next  = '0;
                found_next = 1'b0;
                if (op_reg == OP_INSERT)
                    len_next = len_reg + LW'(1);
                else if (op_reg == OP_POP)
                    len_next = len_reg - LW'(1);
                else if (func_reg == FN_CLEAR)
                    len_next = '0;
                if (func_reg == FN_FIND || func_reg == FN_COUNT || func_reg == FN_REPLACE)
                    state_next = S_SCAN;
                else
                    state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (sc_reg == len_reg)
                begin
                    if (func_reg == FN_FIND && !found_reg)
                        st_next = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    if (match_reg[0])
                    begin
                        cnt_next = cnt_reg + LW'(1);
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next  = sc_reg;
                        end
                    end
                    match_next = match_reg >> 1;
                    sc_next    = sc_reg + LW'(1);
                end
            end
            S_DONE:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.read_value  = 32'(rd_reg);
    assign rsp.found_index = (func_reg == FN_FIND) ? 8'(fidx_reg) : 8'd0;
    assign rsp.match_count = (func_reg == FN_COUNT || func_reg == FN_REPLACE)
                             ? 9'(cnt_reg) : 9'd0;
    assign rsp.list_len    = 9'(len_reg);
    assign rsp.status      = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_reg    <= sc_next;
        cnt_reg   <= cnt_next;
        fidx_reg  <= fidx_next;
        found_reg <= found_next;
        func_reg  <= func_next;
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        nval_reg  <= nval_next;
        st_reg    <= st_next;
        rd_en_reg <= rd_en_next;
        rd_reg    <= rd_next;
        match_reg <= match_next;
    end

endmodule

/* sim/tb_indexed_list_engine_unit.sv */
module tb_indexed_list_engine_unit
    import ile_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 256;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [31:0] read_value;
        logic [7:0]  found_index;
        logic [8:0]  match_count;
        logic [8:0]  list_len;
        logic [1:0]  status;
    } list_result_t;

    typedef struct packed {
        logic [3:0]   func;
        logic [9:0]   position;
        logic [31:0]  item_value;
        logic [31:0]  new_value;
        logic         wait_drain;
        list_result_t result;
    } list_op_t;

    logic clk;
    logic rst_n;

    ile_req_if req ();
    ile_rsp_if rsp ();

    indexed_list_engine_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow list
    logic [31:0] shadow_words [CAPACITY];
    int          shadow_len;

    list_op_t     op_queue [$];
    list_result_t result_queue [$];

    int  errors;
    int  cycles;
    int  results_seen;
    int  stall_left;
    bit  stall_done;
    bit  req_fire;
    logic [31:0] value_pool [4];

    function automatic list_result_t list_apply(logic [3:0] func, logic [9:0] position,
                                                logic [31:0] item_value,
                                                logic [31:0] new_value);
        list_result_t r;
        int p;
        int n;
        r = '0;
        p = $signed(position);
        if (p < 0)
            p = p + shadow_len;
        n = 0;
        case (func)
            FN_GET:
            begin
                if (p >= 0 && p < shadow_len)
                    r.read_value = shadow_words[p];
                else
                    r.status = ST_NOTFOUND;
            end
            FN_SET:
            begin
                if (p >= 0 && p < shadow_len)
                    shadow_words[p] = item_value;
                else
                    r.status = ST_NOTFOUND;
            end
            FN_APPEND:
            begin
                if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = item_value;
                    shadow_len++;
                end
            end
            FN_INSERT:
            begin
                if (p < 0 || p > shadow_len)
                    r.status = ST_NOTFOUND;
                else if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = item_value;
                    shadow_len++;
                end
            end
            FN_POP:
            begin
                if (p >= 0 && p < shadow_len)
                begin
                    r.read_value = shadow_words[p];
                    for (int i = p + 1; i < shadow_len; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_len--;
                end
                else
                    r.status = ST_NOTFOUND;
            end
            FN_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (shadow_words[i] == item_value)
                    begin
                        r.found_index = i[7:0];
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            FN_COUNT, FN_REPLACE:
            begin
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (shadow_words[i] == item_value)
                    begin
                        n++;
                        if (func == FN_REPLACE)
                            shadow_words[i] = new_value;
                    end
                end
                r.match_count = n[8:0];
            end
            FN_CLEAR:
                shadow_len = 0;
            default:
                r.status = ST_NOTFOUND;
        endcase
        r.list_len = shadow_len[8:0];
        return r;
    endfunction

    task automatic queue_op(logic [3:0] func, int position, logic [31:0] item_value,
                            logic [31:0] new_value, bit wait_drain = 0);
        list_op_t op;
        op.func       = func;
        op.position   = position[9:0];
        op.item_value = item_value;
        op.new_value  = new_value;
        op.wait_drain = wait_drain;
        op.result     = list_apply(func, op.position, item_value, new_value);
        op_queue.push_back(op);
    endtask

    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(9);
        if (k < 6)
            return value_pool[$urandom_range(3)];
        else if (k == 6)
            return 32'd0;
        else if (k == 7)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic int pick_position();
        if ($urandom_range(9) < 7)
            return $urandom_range(2 * shadow_len + 2) - shadow_len - 1;
        return $urandom_range(1023);
    endfunction

    // mode 0 grows the list, 1 mixes everything, 2 shrinks it
    task automatic queue_random(int mode);
        int k;
        logic [3:0] func;
        k = $urandom_range(99);
        if (k < 3)
            func = 4'($urandom_range(9, 15));
        else if (k < 4)
            func = FN_CLEAR;
        else if (mode == 0 && k < 85)
            func = (k < 60) ? FN_APPEND : FN_INSERT;
        else if (mode == 2 && k < 70)
            func = FN_POP;
        else
            func = 4'($urandom_range(7));
        queue_op(func, pick_position(), pick_value(), pick_value());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("tb_indexed_list_engine_unit failed");
                $finish;
            end
        end
    end

    // request side: item accepted at posedge, next one offered at negedge
    always @(posedge clk)
        req_fire = req.valid && req.ready;

    always @(posedge clk)
    begin
        if (req.valid && req.ready)
            result_queue.push_back(op_queue.pop_front().result);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (req.valid && !req_fire))
        begin
            if (!rst_n)
                req.valid <= 1'b0;
        end
        else if (op_queue.size() == 0 ||
                 (op_queue[0].wait_drain && result_queue.size() != 0) ||
                 (!(cycles > 20000 && cycles < 40000) && $urandom_range(99) < 8))
            req.valid <= 1'b0;
        else
        begin
            req.valid      <= 1'b1;
            req.func       <= op_queue[0].func;
            req.position   <= op_queue[0].position;
            req.item_value <= op_queue[0].item_value;
            req.new_value  <= op_queue[0].new_value;
        end
    end

    // result side, with one long hold-off once 400 results have come
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready  <= 1'b0;
        end
        else if (!stall_done && results_seen >= 400)
        begin
            stall_done <= 1'b1;
            stall_left <= 400;
            rsp.ready  <= 1'b0;
        end
        else if (cycles > 20000 && cycles < 40000)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (result_queue.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value expected %h actual %h", want.read_value, rsp.read_value);
                    errors++;
                end
                if (rsp.found_index !== want.found_index)
                begin
                    $error("found_index expected %0d actual %0d", want.found_index,
                           rsp.found_index);
                    errors++;
                end
                if (rsp.match_count !== want.match_count)
                begin
                    $error("match_count expected %0d actual %0d", want.match_count,
                           rsp.match_count);
                    errors++;
                end
                if (rsp.list_len !== want.list_len)
                begin
                    $error("list_len expected %0d actual %0d", want.list_len, rsp.list_len);
                    errors++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors       = 0;
        results_seen = 0;
        stall_left   = 0;
        stall_done   = 0;
        req.valid      = 1'b0;
        req.func       = '0;
        req.position   = '0;
        req.item_value = '0;
        req.new_value  = '0;
        rsp.ready      = 1'b0;
        shadow_len     = 0;
        for (int i = 0; i < 4; i++)
            value_pool[i] = (i == 0) ? 32'h5 : $urandom;

        // empty list and small list corner cases
        queue_op(FN_GET, 0, 0, 0);
        queue_op(FN_POP, -1, 0, 0);
        queue_op(FN_FIND, 0, 32'h5, 0);
        queue_op(FN_COUNT, 0, 32'h5, 0);
        queue_op(FN_INSERT, 1, 32'h1, 0);
        queue_op(FN_APPEND, 0, 32'h0, 0);
        queue_op(FN_APPEND, 0, 32'hffff_ffff, 0);
        queue_op(FN_APPEND, 0, 32'h5, 0);
        queue_op(FN_INSERT, 0, 32'h5, 0);
        queue_op(FN_INSERT, 4, 32'haaaa_5555, 0);
        queue_op(FN_INSERT, -1, 32'h5555_aaaa, 0);
        queue_op(FN_INSERT, -512, 32'h1, 0);
        queue_op(FN_SET, -1, 32'h1234_5678, 0);
        queue_op(FN_SET, 6, 32'h1, 0);
        queue_op(FN_GET, 511, 0, 0);
        queue_op(FN_GET, -6, 0, 0);
        queue_op(FN_POP, 2, 0, 0);
        queue_op(FN_FIND, 0, 32'h5, 0);
        queue_op(FN_FIND, 0, 32'h7, 0);
        queue_op(FN_REPLACE, 0, 32'h5, 32'hffff_ffff);
        queue_op(FN_COUNT, 0, 32'hffff_ffff, 0);
        queue_op(4'd9, 0, 0, 0);
        queue_op(4'd15, 0, 0, 0);
        queue_op(FN_CLEAR, 0, 0, 0);

        // random phases: grow, mix, shrink, grow again
        queue_op(FN_GET, 0, 0, 0, 1);
        for (int ph = 0; ph < 4; ph++)
            for (int n = 0; n < 300; n++)
                queue_random(ph == 3 ? 0 : ph);

        wait (rst_n);
        while (op_queue.size() != 0 || result_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_indexed_list_engine_unit passed");
        else
            $display("tb_indexed_list_engine_unit failed");
        $finish;
    end

endmodule
